/* sv/cga_pkg.sv */
// ----------------------------------------------------------------------------
// cga_pkg
// Types and constants shared by the consecutive group aggregator modules.
// ----------------------------------------------------------------------------
package cga_pkg;

  localparam int unsigned RESULT_DEPTH = 4;

  typedef logic [1:0] agg_mode_t;

  localparam agg_mode_t MODE_MAX  = 2'd0;
  localparam agg_mode_t MODE_SUM  = 2'd1;
  localparam agg_mode_t MODE_AREA = 2'd2;

  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] group_key;
    logic signed [31:0] area_value;
    logic signed [31:0] data_value;
    logic               table_end;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic signed [47:0] out_value;
    logic               table_done;
  } out_word_t;

  typedef struct packed {
    logic               group_open;
    logic signed [31:0] current_key;
    logic signed [31:0] best_area;
    logic signed [47:0] running_value;
  } fold_state_t;

endpackage

/* sv/consecutive_group_aggregator_top.sv */
// ----------------------------------------------------------------------------
// consecutive_group_aggregator_top
// Run-length group-by over streamed rows: maximum, saturating sum, or the
// value at the row of greatest area, one result word per closed group.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle into an input register; from there each row
// is folded into the open group and any results are written into a four-entry
// result queue once the queue has room to take them.
// A row waits in the input register while the queue holds more than two
// words, so throughput is one row per cycle as long as results are drained
// at the rate they are made. A row that both changes key and ends the table
// yields two words. Write aggregate_mode only while no rows are in flight.
module consecutive_group_aggregator_top #(
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cga_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cga_pkg::out_word_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data
);

  localparam int unsigned KEY_CMP_W = (KEY_WIDTH > 32) ? 32 : KEY_WIDTH;
  localparam int unsigned DATA_W    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;

  cga_pkg::agg_mode_t   aggregate_mode;
  cga_pkg::in_word_t    row;
  logic                 row_valid;
  cga_pkg::fold_state_t state;
  cga_pkg::fold_state_t state_next;
  logic [1:0]           fold_push_n;
  logic [1:0]           push_n;
  cga_pkg::out_word_t   res0;
  cga_pkg::out_word_t   res1;
  logic                 room;
  logic                 advance;

  assign advance  = row_valid && room;
  assign in_ready = !row_valid || room;
  assign push_n   = advance ? fold_push_n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      aggregate_mode <= cga_pkg::MODE_MAX;
    end else if (cfg_write) begin
      aggregate_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      row <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        row_valid <= 1'b1;
      end else if (advance) begin
        row_valid <= 1'b0;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  cga_fold #(
    .KEY_CMP_W (KEY_CMP_W),
    .DATA_W    (DATA_W)
  ) u_fold (
    .row        (row),
    .mode       (aggregate_mode),
    .state      (state),
    .state_next (state_next),
    .push_n     (fold_push_n),
    .res0       (res0),
    .res1       (res1)
  );

  cga_result_fifo u_results (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sv/cga_fold.sv */
// ----------------------------------------------------------------------------
// cga_fold
// Folds one row into the open group and forms the results of closed groups.
// ----------------------------------------------------------------------------
module cga_fold #(
  parameter int unsigned KEY_CMP_W = 32,
  parameter int unsigned DATA_W    = 32
) (
  input  cga_pkg::in_word_t    row,
  input  cga_pkg::agg_mode_t   mode,
  input  cga_pkg::fold_state_t state,
  output cga_pkg::fold_state_t state_next,
  output logic [1:0]           push_n,
  output cga_pkg::out_word_t   res0,
  output cga_pkg::out_word_t   res1
);

  logic [DATA_W-1:0]  data_low;
  logic signed [47:0] data48;
  logic signed [48:0] sum49;
  logic signed [47:0] sum_sat;
  logic               close_grp;
  logic               first_row;
  cga_pkg::out_word_t old_res;
  cga_pkg::out_word_t end_res;

  assign data_low  = row.data_value[DATA_W-1:0];
  assign data48    = {{(48-DATA_W){data_low[DATA_W-1]}}, data_low};
  assign sum49     = {state.running_value[47], state.running_value} + {data48[47], data48};
  assign close_grp = state.group_open &&
                     (row.group_key[KEY_CMP_W-1:0] != state.current_key[KEY_CMP_W-1:0]);
  assign first_row = !state.group_open || close_grp;

  always_comb begin
    if (sum49[48] != sum49[47]) begin
      sum_sat = sum49[48] ? cga_pkg::SUM_MIN : cga_pkg::SUM_MAX;
    end else begin
      sum_sat = sum49[47:0];
    end
  end

  always_comb begin
    state_next = state;
    if (first_row) begin
      state_next.current_key   = row.group_key;
      state_next.best_area     = row.area_value;
      state_next.running_value = data48;
    end else begin
      unique case (mode)
        cga_pkg::MODE_SUM: begin
          state_next.running_value = sum_sat;
        end
        cga_pkg::MODE_AREA: begin
          // ties keep the earlier row
          if (row.area_value > state.best_area) begin
            state_next.best_area     = row.area_value;
            state_next.running_value = data48;
          end
        end
        default: begin
          if (data48 > state.running_value) begin
            state_next.running_value = data48;
          end
        end
      endcase
    end
    state_next.group_open = !row.table_end;
  end

  always_comb begin
    old_res.out_key    = state.current_key;
    old_res.out_value  = state.running_value;
    old_res.table_done = 1'b0;
    end_res.out_key    = state_next.current_key;
    end_res.out_value  = state_next.running_value;
    end_res.table_done = 1'b1;
  end

  assign push_n = {1'b0, close_grp} + {1'b0, row.table_end};
  assign res0   = close_grp ? old_res : end_res;
  assign res1   = end_res;

endmodule

/* sv/cga_result_fifo.sv */
// ----------------------------------------------------------------------------
// cga_result_fifo
// Small result queue taking up to two words a cycle and giving one.
// ----------------------------------------------------------------------------
module cga_result_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_n,
  input  cga_pkg::out_word_t push0,
  input  cga_pkg::out_word_t push1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output cga_pkg::out_word_t out_data
);

  localparam int unsigned PTR_W = $clog2(cga_pkg::RESULT_DEPTH);
  localparam int unsigned CNT_W = $clog2(cga_pkg::RESULT_DEPTH + 1);

  cga_pkg::out_word_t mem [cga_pkg::RESULT_DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rptr];
  // leave space for a row that closes two groups
  assign room      = (count <= CNT_W'(cga_pkg::RESULT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wptr + PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_n);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

endmodule

/* tb/sv/tb_consecutive_group_aggregator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_consecutive_group_aggregator_top
// Streams table rows into the group aggregator and checks every result word
// against a cycle-free model of the run-length group-by held in this bench.
// Directed rows hit the field extremes, area ties, two-word rows and the
// spare mode. Random phases then cover all modes with sender gaps and
// receiver stalls, and same-key runs of extreme values build large sums.
// ----------------------------------------------------------------------------
module tb_consecutive_group_aggregator_top;

  localparam cga_pkg::agg_mode_t MODE_SPARE     = 2'd3;
  localparam int unsigned        WATCHDOG_LIMIT = 2000;
  localparam int unsigned        SETTLE_CYCLES  = 6;
  localparam int unsigned        SAT_RUN        = 16;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  cga_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cga_pkg::out_word_t out_data;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_data  = 2'd0;

  // rows waiting for the driver, and result words the model says are due
  cga_pkg::in_word_t  pending_rows[$];
  cga_pkg::out_word_t group_results_due[$];

  // model of the open group
  cga_pkg::agg_mode_t mode_now  = cga_pkg::MODE_MAX;
  logic               grp_open  = 1'b0;
  logic signed [31:0] grp_key   = '0;
  logic signed [31:0] grp_area  = '0;
  logic signed [47:0] grp_total = '0;

  int unsigned idle_pct        = 0;
  logic        calm            = 1'b0;
  int unsigned in_gap          = 0;
  int unsigned out_stall       = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned rows_accepted   = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count      = 0;

  consecutive_group_aggregator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Fold one accepted row into the open group; queue any words it closes.
  function automatic void fold_row_into_group(cga_pkg::in_word_t row);
    logic signed [47:0] data48;
    logic signed [48:0] sum49;
    cga_pkg::out_word_t word;
    data48 = {{16{row.data_value[31]}}, row.data_value};
    if (grp_open && row.group_key != grp_key) begin
      word.out_key    = grp_key;
      word.out_value  = grp_total;
      word.table_done = 1'b0;
      group_results_due.push_back(word);
      grp_open = 1'b0;
    end
    if (!grp_open) begin
      grp_open  = 1'b1;
      grp_key   = row.group_key;
      grp_area  = row.area_value;
      grp_total = data48;
    end else if (mode_now == cga_pkg::MODE_SUM) begin
      sum49 = {grp_total[47], grp_total} + {data48[47], data48};
      if (sum49 > cga_pkg::SUM_MAX) grp_total = cga_pkg::SUM_MAX;
      else if (sum49 < cga_pkg::SUM_MIN) grp_total = cga_pkg::SUM_MIN;
      else grp_total = sum49[47:0];
    end else if (mode_now == cga_pkg::MODE_AREA) begin
      // strictly greater only: a tie keeps the earlier row
      if (row.area_value > grp_area) begin
        grp_area  = row.area_value;
        grp_total = data48;
      end
    end else if (data48 > grp_total) begin
      grp_total = data48;
    end
    if (row.table_end) begin
      word.out_key    = grp_key;
      word.out_value  = grp_total;
      word.table_done = 1'b1;
      group_results_due.push_back(word);
      grp_open = 1'b0;
    end
  endfunction

  // Mostly small values around zero so keys repeat and areas tie.
  function automatic logic signed [31:0] rand_field(int unsigned span);
    unique case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom();
      default: return int'($urandom_range(0, 2 * span)) - int'(span);
    endcase
  endfunction

  function automatic void push_row(logic signed [31:0] key, logic signed [31:0] area,
                                   logic signed [31:0] data, logic last);
    cga_pkg::in_word_t w;
    w.group_key  = key;
    w.area_value = area;
    w.data_value = data;
    w.table_end  = last;
    pending_rows.push_back(w);
  endfunction

  // Wait until the driver is drained, nothing is due, and the pipe is empty.
  task automatic settle();
    while (pending_rows.size() != 0 || in_valid || group_results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(cga_pkg::agg_mode_t m);
    settle();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    mode_now = m;
    @(negedge clk);
  endtask

  task automatic queue_random_rows(int unsigned count);
    int unsigned        made;
    int unsigned        len;
    logic signed [31:0] key;
    logic               last;
    made = 0;
    while (made < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 5);
      key = rand_field(6);
      for (int unsigned i = 0; i < len; i++) begin
        last = (i == len - 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 29) == 0);
        push_row(key, rand_field(3), rand_field(1000), last);
      end
      made += len;
    end
  endtask

  // Driver: hold a word until taken, then take the next one or idle.
  always @(posedge clk) begin : drive_rows
    cga_pkg::in_word_t next_word;
    logic              next_valid;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      next_valid = in_valid;
      next_word  = in_data;
      if (in_valid && in_ready) begin
        fold_row_into_group(in_data);
        rows_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else if (!calm && pending_rows.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          in_gap <= $urandom_range(0, 13);
        end else if (pending_rows.size() != 0) begin
          next_valid = 1'b1;
          next_word  = pending_rows.pop_front();
        end
      end
      in_valid <= next_valid;
      in_data  <= next_word;
    end
  end

  // Monitor: compare each taken result word with the oldest one due.
  always @(posedge clk) begin : check_results
    cga_pkg::out_word_t due;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (group_results_due.size() == 0) begin
          $error("result word with nothing due: out_key %0d out_value %0d",
                 out_data.out_key, out_data.out_value);
          fail_count++;
        end else begin
          due = group_results_due.pop_front();
          results_checked++;
          if (out_data.out_key !== due.out_key) begin
            $error("out_key: expected %0d, got %0d", due.out_key, out_data.out_key);
            fail_count++;
          end
          if (out_data.out_value !== due.out_value) begin
            $error("out_value: expected %0d, got %0d", due.out_value, out_data.out_value);
            fail_count++;
          end
          if (out_data.table_done !== due.table_done) begin
            $error("table_done: expected %0b, got %0b", due.table_done, out_data.table_done);
            fail_count++;
          end
        end
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cga_pkg::agg_mode_t phase_modes[8];
    int unsigned        phase_idle[8];
    phase_modes = '{cga_pkg::MODE_MAX, cga_pkg::MODE_SUM, cga_pkg::MODE_AREA, MODE_SPARE,
                    cga_pkg::MODE_AREA, cga_pkg::MODE_SUM, cga_pkg::MODE_MAX,
                    cga_pkg::MODE_MAX};
    phase_idle  = '{25, 10, 0, 30, 15, 25, 5, 20};
    phase_modes[7] = cga_pkg::agg_mode_t'($urandom_range(0, 3));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows, maximum
    idle_pct = 20;
    set_mode(cga_pkg::MODE_MAX);
    push_row(0, 0, -5, 1'b0);
    push_row(0, 7, 32'sh7FFF_FFFF, 1'b0);
    push_row(0, 7, 32'sh8000_0000, 1'b0);
    push_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    push_row(32'sh8000_0000, -1, -1, 1'b1);
    // no group open and table end on one row
    push_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    push_row(-1, 3, 10, 1'b0);
    // key change and table end together: two words
    push_row(5, 3, 20, 1'b1);

    set_mode(cga_pkg::MODE_SUM);
    push_row(1, 0, 32'sh7FFF_FFFF, 1'b0);
    push_row(1, 0, 32'sh7FFF_FFFF, 1'b0);
    push_row(1, 0, 32'sh8000_0000, 1'b0);
    push_row(1, 0, -1, 1'b1);

    set_mode(cga_pkg::MODE_AREA);
    push_row(2, 32'sh8000_0000, 100, 1'b0);
    push_row(2, 32'sh8000_0000, 200, 1'b0);
    push_row(2, 6, 300, 1'b0);
    push_row(2, 32'sh7FFF_FFFF, 400, 1'b0);
    push_row(2, 32'sh7FFF_FFFF, 500, 1'b0);
    push_row(2, 32'sh8000_0000, 600, 1'b1);

    // spare mode folds as maximum; leave the group open across a mode change
    set_mode(MODE_SPARE);
    push_row(3, 0, -7, 1'b0);
    push_row(3, 0, -9, 1'b0);
    push_row(3, 0, -2, 1'b0);
    set_mode(cga_pkg::MODE_SUM);
    push_row(3, 0, 4, 1'b1);

    for (int p = 0; p < 8; p++) begin
      idle_pct = phase_idle[p];
      set_mode(phase_modes[p]);
      queue_random_rows(200);
    end

    // no idling from here on; same-key runs of extreme values build large sums
    calm = 1'b1;
    set_mode(cga_pkg::MODE_SUM);
    for (int unsigned i = 0; i < SAT_RUN; i++)
      push_row(77, 0, 32'sh7FFF_FFFF, 1'b0);
    push_row(77, 0, 32'sh8000_0000, 1'b0);
    push_row(77, 0, 5, 1'b1);
    for (int unsigned i = 0; i < SAT_RUN; i++)
      push_row(-77, 0, 32'sh8000_0000, 1'b0);
    push_row(-77, 0, 32'sh7FFF_FFFF, 1'b1);

    set_mode(cga_pkg::MODE_AREA);
    queue_random_rows(60);
    push_row(32'sh7FFF_FFFF, 0, 0, 1'b1);
    settle();

    if (group_results_due.size() != 0) begin
      $error("%0d result words never arrived", group_results_due.size());
      fail_count++;
    end
    $display("Checked %0d result words from %0d rows over all four mode codes,",
             results_checked, rows_accepted);
    $display("with mode changes in open groups and long sums of both signs.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/cga_pkg.sv
sv/cga_fold.sv
sv/cga_result_fifo.sv
sv/consecutive_group_aggregator_top.sv
tb/sv/tb_consecutive_group_aggregator_top.sv
